// ----- rtl/bsc_pkg.sv -----
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and the compensation microprogram.
// ---------------------------------------------------------------------------
package bsc_pkg;

   localparam int RawWidth  = 20;
   localparam int CoefWidth = 48;
   localparam int CompWidth = 32;
   localparam int IdxWidth  = 2;
   localparam int PcWidth   = 6;

   localparam logic [IdxWidth-1:0] CSR_TEMP    = 2'd0;
   localparam logic [IdxWidth-1:0] CSR_PRESS_A = 2'd1;
   localparam logic [IdxWidth-1:0] CSR_PRESS_B = 2'd2;
   localparam logic [IdxWidth-1:0] CSR_PRESS_C = 2'd3;

   localparam logic [PcWidth-1:0] PC_TEMP  = 6'd0;
   localparam logic [PcWidth-1:0] PC_PRESS = 6'd16;

   localparam logic [2:0] R0 = 3'd0;
   localparam logic [2:0] R1 = 3'd1;
   localparam logic [2:0] R2 = 3'd2;
   localparam logic [2:0] R3 = 3'd3;
   localparam logic [2:0] R4 = 3'd4;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_ASR, OP_MUL, OP_DIV, OP_SEXT, OP_TSTZ
   } op_type;

   typedef enum logic [4:0] {
      S_R0, S_R1, S_R2, S_R3, S_R4, S_RAW, S_FINE,
      S_T1, S_T2, S_T3,
      S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
      S_K5, S_K128, S_K128000, S_K2P47, S_K2P20, S_K3125
   } src_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] dst;
      src_type    srca;
      src_type    srcb;
      logic [5:0] sh;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic    load_in;
      logic    issue;
      logic    load_out;
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic a_zero;
   } dp_status_type;

   function automatic uop_type mk(op_type op, logic [2:0] d, src_type a, src_type b,
                                  logic [5:0] s, logic l);
      uop_type u;
      u.op = op; u.dst = d; u.srca = a; u.srcb = b; u.sh = s; u.last = l;
      return u;
   endfunction

   // Temperature program from PC_TEMP, pressure program from PC_PRESS.
   function automatic uop_type ucode(logic [PcWidth-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_SHR,  R0, S_RAW,  S_R0,   6'd3,  1'b0);
         6'd1:  u = mk(OP_SHL,  R1, S_T1,   S_R0,   6'd1,  1'b0);
         6'd2:  u = mk(OP_SUB,  R0, S_R0,   S_R1,   6'd0,  1'b0);
         6'd3:  u = mk(OP_MUL,  R0, S_R0,   S_T2,   6'd0,  1'b0);
         6'd4:  u = mk(OP_ASR,  R0, S_R0,   S_R0,   6'd11, 1'b0);
         6'd5:  u = mk(OP_SHR,  R1, S_RAW,  S_R0,   6'd4,  1'b0);
         6'd6:  u = mk(OP_SUB,  R1, S_R1,   S_T1,   6'd0,  1'b0);
         6'd7:  u = mk(OP_MUL,  R1, S_R1,   S_R1,   6'd0,  1'b0);
         6'd8:  u = mk(OP_ASR,  R1, S_R1,   S_R0,   6'd12, 1'b0);
         6'd9:  u = mk(OP_MUL,  R1, S_R1,   S_T3,   6'd0,  1'b0);
         6'd10: u = mk(OP_ASR,  R1, S_R1,   S_R0,   6'd14, 1'b0);
         6'd11: u = mk(OP_ADD,  R0, S_R0,   S_R1,   6'd0,  1'b0);
         6'd12: u = mk(OP_SEXT, R0, S_R0,   S_R0,   6'd0,  1'b0);
         6'd13: u = mk(OP_MUL,  R0, S_R0,   S_K5,   6'd0,  1'b0);
         6'd14: u = mk(OP_ADD,  R0, S_R0,   S_K128, 6'd0,  1'b0);
         6'd15: u = mk(OP_ASR,  R0, S_R0,   S_R0,   6'd8,  1'b1);
         6'd16: u = mk(OP_SUB,  R0, S_FINE, S_K128000, 6'd0, 1'b0);
         6'd17: u = mk(OP_MUL,  R1, S_R0,   S_R0,   6'd0,  1'b0);
         6'd18: u = mk(OP_MUL,  R2, S_R1,   S_P6,   6'd0,  1'b0);
         6'd19: u = mk(OP_MUL,  R3, S_R0,   S_P5,   6'd0,  1'b0);
         6'd20: u = mk(OP_SHL,  R3, S_R3,   S_R0,   6'd17, 1'b0);
         6'd21: u = mk(OP_ADD,  R2, S_R2,   S_R3,   6'd0,  1'b0);
         6'd22: u = mk(OP_SHL,  R3, S_P4,   S_R0,   6'd35, 1'b0);
         6'd23: u = mk(OP_ADD,  R2, S_R2,   S_R3,   6'd0,  1'b0);
         6'd24: u = mk(OP_MUL,  R1, S_R1,   S_P3,   6'd0,  1'b0);
         6'd25: u = mk(OP_ASR,  R1, S_R1,   S_R0,   6'd8,  1'b0);
         6'd26: u = mk(OP_MUL,  R3, S_R0,   S_P2,   6'd0,  1'b0);
         6'd27: u = mk(OP_SHL,  R3, S_R3,   S_R0,   6'd12, 1'b0);
         6'd28: u = mk(OP_ADD,  R0, S_R1,   S_R3,   6'd0,  1'b0);
         6'd29: u = mk(OP_ADD,  R0, S_K2P47, S_R0,  6'd0,  1'b0);
         6'd30: u = mk(OP_MUL,  R0, S_R0,   S_P1,   6'd0,  1'b0);
         6'd31: u = mk(OP_ASR,  R0, S_R0,   S_R0,   6'd33, 1'b0);
         6'd32: u = mk(OP_TSTZ, R0, S_R0,   S_R0,   6'd0,  1'b0);
         6'd33: u = mk(OP_SUB,  R1, S_K2P20, S_RAW, 6'd0,  1'b0);
         6'd34: u = mk(OP_SHL,  R1, S_R1,   S_R0,   6'd31, 1'b0);
         6'd35: u = mk(OP_SUB,  R1, S_R1,   S_R2,   6'd0,  1'b0);
         6'd36: u = mk(OP_MUL,  R1, S_R1,   S_K3125, 6'd0, 1'b0);
         6'd37: u = mk(OP_DIV,  R1, S_R1,   S_R0,   6'd0,  1'b0);
         6'd38: u = mk(OP_ASR,  R2, S_R1,   S_R0,   6'd13, 1'b0);
         6'd39: u = mk(OP_MUL,  R3, S_P9,   S_R2,   6'd0,  1'b0);
         6'd40: u = mk(OP_MUL,  R3, S_R3,   S_R2,   6'd0,  1'b0);
         6'd41: u = mk(OP_ASR,  R3, S_R3,   S_R0,   6'd25, 1'b0);
         6'd42: u = mk(OP_MUL,  R4, S_P8,   S_R1,   6'd0,  1'b0);
         6'd43: u = mk(OP_ASR,  R4, S_R4,   S_R0,   6'd19, 1'b0);
         6'd44: u = mk(OP_ADD,  R1, S_R1,   S_R3,   6'd0,  1'b0);
         6'd45: u = mk(OP_ADD,  R1, S_R1,   S_R4,   6'd0,  1'b0);
         6'd46: u = mk(OP_ASR,  R1, S_R1,   S_R0,   6'd8,  1'b0);
         6'd47: u = mk(OP_SHL,  R3, S_P7,   S_R0,   6'd4,  1'b0);
         6'd48: u = mk(OP_ADD,  R0, S_R1,   S_R3,   6'd0,  1'b1);
         default: u = mk(OP_ADD, R0, S_R0, S_R0, 6'd0, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/bsc_datapath.sv -----
// ---------------------------------------------------------------------------
// bsc_datapath
// Coefficient registers, working registers, ALU, 64x16 iterative multiplier
// and radix-2 signed divider.
// ---------------------------------------------------------------------------
module bsc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [bsc_pkg::IdxWidth-1:0]    csr_index,
   input  logic [bsc_pkg::CoefWidth-1:0]   csr_data,
   input  logic [bsc_pkg::RawWidth-1:0]    raw_reading,
   input  bsc_pkg::dp_cmd_type             cmd,
   output bsc_pkg::dp_status_type          status,
   output logic [bsc_pkg::CompWidth-1:0]   comp_value,
   output logic                            divide_by_zero
);
   import bsc_pkg::*;

   logic [CoefWidth-1:0] temp_ff, pa_ff, pb_ff, pc_ff;
   logic [31:0]          fine_ff;
   logic [RawWidth-1:0]  raw_ff;
   logic [63:0]          r0_ff, r1_ff, r2_ff, r3_ff, r4_ff;
   logic                 zflag_ff;
   logic [CompWidth-1:0] comp_ff;
   logic                 flag_ff;

   logic                 mbusy_ff, dbusy_ff, dneg_ff;
   logic [5:0]           cnt_ff;
   logic [63:0]          ma_ff, mb_ff, acc_ff;
   logic [63:0]          rem_ff, quo_ff, den_ff;

   logic [63:0] opa, opb, alu, wdata;
   logic        wen;
   logic [79:0] prod;
   logic [63:0] mul_res;
   logic [64:0] dsh;
   logic        dge;
   logic [63:0] rem_n, quo_n, div_res;
   logic        mdone, ddone;
   uop_type     u;

   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] pick(src_type s);
      logic [63:0] v;
      case (s)
         S_R0:      v = r0_ff;
         S_R1:      v = r1_ff;
         S_R2:      v = r2_ff;
         S_R3:      v = r3_ff;
         S_R4:      v = r4_ff;
         S_RAW:     v = {44'd0, raw_ff};
         S_FINE:    v = {{32{fine_ff[31]}}, fine_ff};
         S_T1:      v = {48'd0, temp_ff[15:0]};
         S_T2:      v = sx16(temp_ff[31:16]);
         S_T3:      v = sx16(temp_ff[47:32]);
         S_P1:      v = {48'd0, pa_ff[15:0]};
         S_P2:      v = sx16(pa_ff[31:16]);
         S_P3:      v = sx16(pa_ff[47:32]);
         S_P4:      v = sx16(pb_ff[15:0]);
         S_P5:      v = sx16(pb_ff[31:16]);
         S_P6:      v = sx16(pb_ff[47:32]);
         S_P7:      v = sx16(pc_ff[15:0]);
         S_P8:      v = sx16(pc_ff[31:16]);
         S_P9:      v = sx16(pc_ff[47:32]);
         S_K5:      v = 64'd5;
         S_K128:    v = 64'd128;
         S_K128000: v = 64'd128000;
         S_K2P47:   v = 64'h0000_8000_0000_0000;
         S_K2P20:   v = 64'd1048576;
         S_K3125:   v = 64'd3125;
         default:   v = 64'd0;
      endcase
      return v;
   endfunction

   assign u = cmd.uop;

   always_comb begin
      opa = pick(u.srca);
      opb = pick(u.srcb);
   end

   always_comb begin
      case (u.op)
         OP_ADD:  alu = opa + opb;
         OP_SUB:  alu = opa - opb;
         OP_SHL:  alu = opa << u.sh;
         OP_SHR:  alu = opa >> u.sh;
         OP_ASR:  alu = $unsigned($signed(opa) >>> u.sh);
         OP_SEXT: alu = {{32{opa[31]}}, opa[31:0]};
         default: alu = opa;
      endcase
   end

   // multiplier: one 16-bit slice of the second operand per cycle
   assign prod    = ma_ff * mb_ff[15:0];
   assign mul_res = acc_ff + prod[63:0];
   assign mdone   = mbusy_ff && (cnt_ff[1:0] == 2'd3);

   // divider: one quotient bit per cycle on magnitudes
   assign dsh     = {rem_ff, quo_ff[63]};
   assign dge     = dsh >= {1'b0, den_ff};
   assign rem_n   = dge ? 64'(dsh - {1'b0, den_ff}) : dsh[63:0];
   assign quo_n   = {quo_ff[62:0], dge};
   assign div_res = dneg_ff ? 64'(0 - quo_n) : quo_n;
   assign ddone   = dbusy_ff && (cnt_ff == 6'd63);

   assign status.done   = mdone || ddone;
   assign status.a_zero = (opa == 64'd0);

   always_comb begin
      wen   = 1'b0;
      wdata = alu;
      if (mdone) begin
         wen   = 1'b1;
         wdata = mul_res;
      end else if (ddone) begin
         wen   = 1'b1;
         wdata = div_res;
      end else if (cmd.issue && u.op != OP_MUL && u.op != OP_DIV && u.op != OP_TSTZ) begin
         wen = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         pa_ff    <= '0;
         pb_ff    <= '0;
         pc_ff    <= '0;
         fine_ff  <= '0;
         mbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TEMP:    temp_ff <= csr_data;
               CSR_PRESS_A: pa_ff   <= csr_data;
               CSR_PRESS_B: pb_ff   <= csr_data;
               CSR_PRESS_C: pc_ff   <= csr_data;
               default:     ;
            endcase
         end
         if (cmd.issue && u.op == OP_SEXT) begin
            fine_ff <= opa[31:0];
         end
         if (cmd.issue && u.op == OP_MUL) begin
            mbusy_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (cmd.issue && u.op == OP_DIV) begin
            dbusy_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (mdone || ddone) begin
            mbusy_ff <= 1'b0;
            dbusy_ff <= 1'b0;
         end else if (mbusy_ff || dbusy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_ff   <= raw_reading;
         zflag_ff <= 1'b0;
      end
      if (cmd.issue && u.op == OP_TSTZ) begin
         zflag_ff <= status.a_zero;
      end
      if (cmd.issue && u.op == OP_MUL) begin
         ma_ff  <= opa;
         mb_ff  <= opb;
         acc_ff <= '0;
      end else if (mbusy_ff) begin
         acc_ff <= mul_res;
         ma_ff  <= ma_ff << 16;
         mb_ff  <= mb_ff >> 16;
      end
      if (cmd.issue && u.op == OP_DIV) begin
         dneg_ff <= opa[63] ^ opb[63];
         quo_ff  <= opa[63] ? 64'(0 - opa) : opa;
         den_ff  <= opb[63] ? 64'(0 - opb) : opb;
         rem_ff  <= '0;
      end else if (dbusy_ff) begin
         rem_ff <= rem_n;
         quo_ff <= quo_n;
      end
      if (wen) begin
         case (u.dst)
            R0:      r0_ff <= wdata;
            R1:      r1_ff <= wdata;
            R2:      r2_ff <= wdata;
            R3:      r3_ff <= wdata;
            R4:      r4_ff <= wdata;
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         comp_ff <= zflag_ff ? '0 : r0_ff[CompWidth-1:0];
         flag_ff <= zflag_ff;
      end
   end

   assign comp_value     = comp_ff;
   assign divide_by_zero = flag_ff;

endmodule

// ----- rtl/bsc_control.sv -----
// ---------------------------------------------------------------------------
// bsc_control
// Sequencer: steps the microprogram and owns the stream handshakes.
// ---------------------------------------------------------------------------
module bsc_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output bsc_pkg::dp_cmd_type    cmd,
   input  bsc_pkg::dp_status_type status
);
   import bsc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [PcWidth-1:0]   pc_ff, pc_in;
   logic                 valid_ff, valid_in;
   uop_type              u;
   logic                 is_long;

   assign u          = ucode(pc_ff);
   assign is_long    = (u.op == OP_MUL) || (u.op == OP_DIV);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      valid_in     = valid_ff && !rsp_tready;
      cmd.uop      = u;
      cmd.load_in  = 1'b0;
      cmd.issue    = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               pc_in       = req_cmd ? PC_PRESS : PC_TEMP;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (is_long) begin
               state_in = ST_WAIT;
            end else if (u.last || (u.op == OP_TSTZ && status.a_zero)) begin
               state_in = ST_FINISH;
            end else begin
               pc_in = pc_ff + 6'd1;
            end
         end
         ST_WAIT: begin
            if (status.done) begin
               if (u.last) begin
                  state_in = ST_FINISH;
               end else begin
                  pc_in    = pc_ff + 6'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         valid_ff <= valid_in;
      end
   end

   a_long_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && is_long) |=> state_ff == ST_WAIT)
      else $error("long op did not enter wait");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && !status.done) |=> (state_ff == ST_WAIT && $stable(pc_ff)))
      else $error("wait left before unit finished");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_ISSUE)
      else $error("accepted item did not start");

endmodule

// ----- rtl/baro_sensor_compensation.sv -----
// ---------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ---------------------------------------------------------------------------
// Usage:
//   csr_*  : write the four 48-bit coefficient registers (index 0 temperature,
//            1..3 pressure groups) while the block is idle; always ready.
//   req_*  : one raw 20-bit reading in tdata, the command in tuser
//            (0 temperature, 1 pressure). Taken only when the block is idle.
//   rsp_*  : comp_value in tdata, divide_by_zero flag in tuser.
// A temperature item also stores the fine temperature that later pressure
// items use. The time per item is set by the microprogram length, the
// iterative 64x16 multiplier and the radix-2 divider. One item is in
// flight at a time; the output register lets the next item be accepted while
// a result still waits. If the receiver stalls, a finished second result
// holds in the sequencer until the output register frees.
// Reset (synchronous) clears the coefficients, the fine temperature and the
// handshakes; no clearing pass is needed.
// ---------------------------------------------------------------------------
module baro_sensor_compensation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsc_pkg::IdxWidth-1:0]  csr_index,
   input  logic [bsc_pkg::CoefWidth-1:0] csr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // [19:0] raw_reading, rest zero
   input  logic                          req_tuser,   // [0] cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // [31:0] comp_value
   output logic                          rsp_tuser    // [0] divide_by_zero
);
   import bsc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration writes land at once
   assign csr_ready = 1'b1;

   bsc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bsc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .raw_reading    (req_tdata[RawWidth-1:0]),
      .cmd            (cmd),
      .status         (status),
      .comp_value     (rsp_tdata),
      .divide_by_zero (rsp_tuser)
   );

endmodule

// ----- tb/baro_sensor_compensation_test.sv -----
// ---------------------------------------------------------------------------
// baro_sensor_compensation_test
// Self-checking testbench for the barometric compensation block. A clocked
// driver sends readings from a pending queue while a monitor predicts each
// accepted item in 64-bit integer form. It compares every result with the
// oldest prediction. Coefficient sets change between phases while the block
// is idle.
// ---------------------------------------------------------------------------
module baro_sensor_compensation_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam logic CmdTemp  = 1'b0;
   localparam logic CmdPress = 1'b1;

   typedef struct {
      logic        cmd;
      logic [19:0] raw;
      bit          drain;   // hold this item until every result is back
   } reading_type;

   typedef struct {
      logic [31:0] comp;
      logic        dbz;
   } comp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [IdxWidth-1:0]  csr_index = '0;
   logic [CoefWidth-1:0] csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;

   reading_type pending_q[$];
   comp_type    comp_q[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   logic        req_fire = 1'b0;

   // Predictor copy of the coefficients and the stored fine temperature.
   logic [47:0] coef_temp, coef_pa, coef_pb, coef_pc;
   logic [31:0] fine_temp;

   always #4 clock = ~clock;

   baro_sensor_compensation DUT (.*);

   function automatic logic [63:0] asr64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] sx16(logic [47:0] r, int slot);
      logic [15:0] v;
      v = r[16*slot +: 16];
      return {{48{v[15]}}, v};
   endfunction

   // Signed divide truncating toward zero on bit patterns.
   function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? 64'd0 - n : n;
      ad = d[63] ? 64'd0 - d : d;
      q  = an / ad;
      return (n[63] != d[63]) ? 64'd0 - q : q;
   endfunction

   function automatic comp_type compensate(logic cmd, logic [19:0] raw_in);
      comp_type    c;
      logic [63:0] raw, t1, d1, d2, v1, v2, tf, p, q;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      raw = {44'd0, raw_in};
      c.dbz = 1'b0;
      if (cmd == CmdTemp) begin
         t1 = {48'd0, coef_temp[15:0]};
         d1 = (raw >> 3) - (t1 << 1);
         v1 = asr64(d1 * sx16(coef_temp, 1), 11);
         d2 = (raw >> 4) - t1;
         v2 = asr64(asr64(d2 * d2, 12) * sx16(coef_temp, 2), 14);
         tf = v1 + v2;
         fine_temp = tf[31:0];
         tf = {{32{fine_temp[31]}}, fine_temp};
         tf = asr64(tf * 64'd5 + 64'd128, 8);
         c.comp = tf[31:0];
      end else begin
         p1 = {48'd0, coef_pa[15:0]};
         p2 = sx16(coef_pa, 1);
         p3 = sx16(coef_pa, 2);
         p4 = sx16(coef_pb, 0);
         p5 = sx16(coef_pb, 1);
         p6 = sx16(coef_pb, 2);
         p7 = sx16(coef_pc, 0);
         p8 = sx16(coef_pc, 1);
         p9 = sx16(coef_pc, 2);
         v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) << 17);
         v2 = v2 + (p4 << 35);
         v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
         v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
         if (v1 == 64'd0) begin
            c.comp = '0;
            c.dbz  = 1'b1;
         end else begin
            p  = 64'd1048576 - raw;
            p  = div_trunc(((p << 31) - v2) * 64'd3125, v1);
            q  = asr64(p, 13);
            v1 = asr64(p9 * q * q, 25);
            v2 = asr64(p8 * p, 19);
            p  = asr64(p + v1 + v2, 8) + (p7 << 4);
            c.comp = p[31:0];
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // Monitor: track configuration, predict accepted items, check results.
   always @(posedge clock) begin
      comp_type w;
      req_fire <= req_tvalid && req_tready;
      if (reset) begin
         coef_temp = '0; coef_pa = '0; coef_pb = '0; coef_pc = '0;
         fine_temp = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP:    coef_temp = csr_data;
               CSR_PRESS_A: coef_pa   = csr_data;
               CSR_PRESS_B: coef_pb   = csr_data;
               CSR_PRESS_C: coef_pc   = csr_data;
            endcase
         end
         if (req_tvalid && req_tready)
            comp_q.push_back(compensate(req_tuser, req_tdata[19:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (comp_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 32'd0);
            end else begin
               w = comp_q.pop_front();
               if (rsp_tdata !== w.comp) report_mismatch("comp_value", rsp_tdata, w.comp);
               if (rsp_tuser !== w.dbz)
                  report_mismatch("divide_by_zero", {31'd0, rsp_tuser}, {31'd0, w.dbz});
            end
         end
         // Watchdog: count cycles with no handshake at all.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
               $display("watchdog expired at %0t", $time);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   // Driver: advance to the next pending item once the current one is taken.
   always @(negedge clock) begin
      reading_type it;
      if (!reset) begin
         if (req_tvalid && !req_fire) begin
            // hold the item until accepted
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_q.size() > 0 &&
                      !(pending_q[0].drain && comp_q.size() > 0)) begin
            it = pending_q.pop_front();
            req_tdata  <= {4'd0, it.raw};
            req_tuser  <= it.cmd;
            req_tvalid <= 1'b1;
            req_gap    <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
         // Receiver: random stalls, mostly short.
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= pick_gap();
         end
      end
   end

   task automatic push_reading(logic cmd, logic [19:0] raw, bit drain = 0);
      reading_type it;
      it.cmd = cmd; it.raw = raw; it.drain = drain;
      pending_q.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || comp_q.size() > 0 || req_tvalid) @(posedge clock);
   endtask

   task automatic write_csr(logic [IdxWidth-1:0] idx, logic [CoefWidth-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_coefs(logic [47:0] t, logic [47:0] a, logic [47:0] b,
                             logic [47:0] c);
      wait_idle();
      write_csr(CSR_TEMP, t);
      write_csr(CSR_PRESS_A, a);
      write_csr(CSR_PRESS_B, b);
      write_csr(CSR_PRESS_C, c);
   endtask

   function automatic logic [19:0] pick_raw(logic cmd);
      case ($urandom_range(9))
         0:       return 20'd0;
         1:       return 20'hFFFFF;
         2, 3, 4: return 20'($urandom_range(1048575));
         default: return cmd ? 20'($urandom_range(450000, 250000))
                             : 20'($urandom_range(560000, 480000));
      endcase
   endfunction

   // Mostly temperature-then-pressure pairs, with some lone items.
   task automatic push_random(int n, bit drain_mid);
      for (int i = 0; i < n; i += 2) begin
         if ($urandom_range(4) == 0) begin
            push_reading(logic'($urandom_range(1)), pick_raw(logic'($urandom_range(1))),
                         drain_mid && i == n / 2);
         end else begin
            push_reading(CmdTemp, pick_raw(CmdTemp));
            push_reading(CmdPress, pick_raw(CmdPress), drain_mid && i == n / 2);
         end
      end
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   localparam logic [47:0] TypTemp = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [47:0] TypPa   = {16'd3024, 16'hD643, 16'd36477};
   localparam logic [47:0] TypPb   = {16'hFFF9, 16'd140, 16'd2855};
   localparam logic [47:0] TypPc   = {16'd6000, 16'hC6F8, 16'd15500};

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: typical coefficients, pressure before any temperature.
      load_coefs(TypTemp, TypPa, TypPb, TypPc);
      push_reading(CmdPress, 20'd415148);
      push_reading(CmdTemp, 20'd519888);
      push_reading(CmdPress, 20'd415148);
      push_reading(CmdTemp, 20'd0);
      push_reading(CmdPress, 20'd0);
      push_reading(CmdTemp, 20'hFFFFF);
      push_reading(CmdPress, 20'hFFFFF);
      push_reading(CmdPress, 20'h55555);
      push_reading(CmdTemp, 20'hAAAAA);
      push_reading(CmdPress, 20'hAAAAA);

      // Zero divisor: P1 of zero.
      load_coefs(TypTemp, {TypPa[47:16], 16'd0}, TypPb, TypPc);
      push_reading(CmdTemp, 20'd519888);
      push_reading(CmdPress, 20'd415148);
      push_reading(CmdPress, 20'hFFFFF);

      // Extreme coefficients: all ones, then all zero.
      load_coefs('1, '1, '1, '1);
      push_reading(CmdTemp, 20'hFFFFF);
      push_reading(CmdPress, 20'hFFFFF);
      push_reading(CmdTemp, 20'd0);
      push_reading(CmdPress, 20'd0);
      load_coefs('0, '0, '0, '0);
      push_reading(CmdTemp, 20'd519888);
      push_reading(CmdPress, 20'd415148);

      // Random phases.
      load_coefs(TypTemp, TypPa, TypPb, TypPc);
      push_random(200, 1);
      load_coefs(rand48(), rand48(), rand48(), rand48());
      push_random(100, 0);
      load_coefs({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
      push_random(60, 0);
      load_coefs(TypTemp ^ {3{4'd0, 12'($urandom)}}, TypPa ^ {3{8'd0, 8'($urandom)}},
                 rand48(), TypPc);
      push_random(160, 1);
      load_coefs(TypTemp, {TypPa[47:16], 16'($urandom_range(3))}, TypPb, TypPc);
      push_random(30, 0);

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0 && comp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
